FILE: sv/quaternion_to_euler_angles_defines.svh
// assertion macros for the quaternion to euler angle converter
// used by the checker, relies on clk and rst_n in the including scope
`ifndef QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_DEFINES_SVH

// checked only outside reset
`define Q2E_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("q2e assertion failed");

// checked also around reset
`define Q2E_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("q2e reset assertion failed");

`endif

FILE: sv/q2e_pkg.sv
// shared constants, types and functions of the quaternion to euler angle converter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package q2e_pkg;

  localparam int QUAT_WIDTH    = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int FRAC_BITS     = QUAT_WIDTH - 2;
  localparam int MAT_FRAC      = 28;
  localparam int PROD_DOWN     = (2 * FRAC_BITS >= MAT_FRAC) ? 2 * FRAC_BITS - MAT_FRAC : 0;
  localparam int PROD_UP       = (2 * FRAC_BITS < MAT_FRAC) ? MAT_FRAC - 2 * FRAC_BITS : 0;
  localparam int PROD_W        = MAT_FRAC + 4;
  localparam int MAT_W         = MAT_FRAC + 8;
  localparam int A_W           = MAT_FRAC + 2;
  localparam int SQ_W          = 2 * MAT_FRAC + 1;
  localparam int ROOT_W        = MAT_FRAC + 1;
  localparam int TRIAL_W       = SQ_W + 2;
  localparam int CW            = MAT_W + 2;
  localparam int ANG_W         = 32;
  localparam int UNITS         = 23040;
  localparam int HALF_UNITS    = 11520;
  localparam int PITCH_LIMIT   = 5760;
  localparam int CONV_W        = ANG_W + 16;
  localparam int ROLL_W        = 15;
  localparam int PITCH_W       = 14;
  localparam int HEAD_W        = 15;
  localparam int IDX_W         = 5;

  localparam logic [ANG_W-1:0] QUARTER_POS = 32'h4000_0000;
  localparam logic [ANG_W-1:0] QUARTER_NEG = 32'hC000_0000;

  typedef logic signed [QUAT_WIDTH-1:0] comp_t;
  typedef logic signed [PROD_W-1:0] prod_val_t;

  typedef struct packed {
    prod_val_t ww, xx, zz, xy, wz, xz, wy, yz, wx;
  } prod_t;

  typedef struct packed {
    logic signed [MAT_W-1:0] m11;
    logic signed [MAT_W-1:0] m12;
    logic signed [MAT_W-1:0] m23;
    logic signed [MAT_W-1:0] m33;
    logic                    clamped;
  } mat_t;

  typedef struct packed {
    logic [SQ_W-1:0]        rem;
    logic [ROOT_W-1:0]      root;
    logic signed [A_W-1:0]  a;
    mat_t                   mat;
  } sq_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [ANG_W-1:0]     z;
    logic                 zero;
  } chan_t;

  typedef struct packed {
    chan_t roll;
    chan_t pitch;
    chan_t yaw;
    logic  clamped;
  } cd_t;

  function automatic prod_val_t prod(input comp_t a, input comp_t b);
    logic signed [2*QUAT_WIDTH-1:0] p;
    prod_val_t r;
    p = a * b;
    r = PROD_W'(p >>> PROD_DOWN);
    return r <<< PROD_UP;
  endfunction

  function automatic logic [ANG_W-1:0] atan_ang(input logic [IDX_W-1:0] i);
    logic [ANG_W-1:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // quadrant fold for a left half-plane vector, zero vector flagged
  function automatic chan_t pre_rotate(input logic signed [CW-1:0] y,
                                       input logic signed [CW-1:0] x);
    chan_t c;
    c.zero = (x == '0) && (y == '0);
    c.x = x;
    c.y = y;
    c.z = '0;
    if (x[CW-1]) begin
      if (!y[CW-1]) begin
        c.x = y;
        c.y = -x;
        c.z = QUARTER_POS;
      end else begin
        c.x = -y;
        c.y = x;
        c.z = QUARTER_NEG;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: sv/q2e_sqrt_cell.sv
// one bit of the floor square root for the pitch cosine, one cell of the root row
// depends on q2e_pkg
`timescale 1ns / 1ps
`default_nettype none
module q2e_sqrt_cell (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic [q2e_pkg::IDX_W-1:0] bit_idx,
  input  wire logic                    up_valid,
  output logic                         up_ready,
  input  wire q2e_pkg::sq_t            up_data,
  output logic                         dn_valid,
  input  wire logic                    dn_ready,
  output q2e_pkg::sq_t                 dn_data
);

  logic                            valid_r;
  q2e_pkg::sq_t                    data_r;
  q2e_pkg::sq_t                    data_nxt;
  logic [q2e_pkg::TRIAL_W-1:0]     trial;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // (root + 2^b)^2 - root^2
  always_comb begin
    trial = (q2e_pkg::TRIAL_W'(up_data.root) << (6'(bit_idx) + 6'd1))
          + (q2e_pkg::TRIAL_W'(1) << {bit_idx, 1'b0});
    data_nxt = up_data;
    if (q2e_pkg::TRIAL_W'(up_data.rem) >= trial) begin
      data_nxt.rem  = up_data.rem - trial[q2e_pkg::SQ_W-1:0];
      data_nxt.root = up_data.root | (q2e_pkg::ROOT_W'(1) << bit_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/q2e_cordic_cell.sv
// one vectoring cordic iteration for roll, pitch and yaw side by side
// depends on q2e_pkg
`timescale 1ns / 1ps
`default_nettype none
module q2e_cordic_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [q2e_pkg::IDX_W-1:0] iter,
  input  wire logic                      up_valid,
  output logic                           up_ready,
  input  wire q2e_pkg::cd_t              up_data,
  output logic                           dn_valid,
  input  wire logic                      dn_ready,
  output q2e_pkg::cd_t                   dn_data
);

  logic                        valid_r;
  q2e_pkg::cd_t                data_r;
  q2e_pkg::cd_t                data_nxt;
  logic [q2e_pkg::ANG_W-1:0]   da;

  function automatic q2e_pkg::chan_t step(input q2e_pkg::chan_t c,
                                          input logic [q2e_pkg::IDX_W-1:0] i,
                                          input logic [q2e_pkg::ANG_W-1:0] ang);
    q2e_pkg::chan_t r;
    logic signed [q2e_pkg::CW-1:0] dx;
    logic signed [q2e_pkg::CW-1:0] dy;
    r  = c;
    dx = c.y >>> i;
    dy = c.x >>> i;
    if (!c.y[q2e_pkg::CW-1]) begin
      r.x = c.x + dx;
      r.y = c.y - dy;
      r.z = c.z + ang;
    end else begin
      r.x = c.x - dx;
      r.y = c.y + dy;
      r.z = c.z - ang;
    end
    return r;
  endfunction

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    da = q2e_pkg::atan_ang(iter);
    data_nxt = up_data;
    data_nxt.roll  = step(up_data.roll, iter, da);
    data_nxt.pitch = step(up_data.pitch, iter, da);
    data_nxt.yaw   = step(up_data.yaw, iter, da);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/quaternion_to_euler_angles.sv
// Quaternion to roll, pitch and yaw (z-y-x order), fully pipelined. One quaternion is
// taken per cycle while the output is not stalled; each passes through the products,
// matrix, radicand, 29-cell square-root row for the pitch cosine, quadrant fold, row of
// CORDIC_STAGES cordic cells, scale and round stages in that order. Each stage holds
// its item until the next one is free, so a stalled output only fills empty stages.
// depends on q2e_pkg, q2e_sqrt_cell and q2e_cordic_cell
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_euler_angles (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // roll_angle, pitch_angle, heading_angle, zero fill
  output logic             out_tuser   // pitch_clamped
);

  localparam int QW = q2e_pkg::QUAT_WIDTH;
  localparam int NSQ = q2e_pkg::ROOT_W;
  localparam int NCD = q2e_pkg::CORDIC_STAGES;
  localparam logic signed [q2e_pkg::MAT_W-1:0] MAT_ONE =
    q2e_pkg::MAT_W'(1) <<< q2e_pkg::MAT_FRAC;

  // products
  logic           v0_r;
  q2e_pkg::prod_t p_r;
  q2e_pkg::prod_t p_nxt;
  logic           rdy0;
  q2e_pkg::comp_t qw, qx, qy, qz;

  assign qw = in_tdata[QW-1:0];
  assign qx = in_tdata[16+QW-1:16];
  assign qy = in_tdata[32+QW-1:32];
  assign qz = in_tdata[48+QW-1:48];

  always_comb begin
    p_nxt.ww = q2e_pkg::prod(qw, qw);
    p_nxt.xx = q2e_pkg::prod(qx, qx);
    p_nxt.zz = q2e_pkg::prod(qz, qz);
    p_nxt.xy = q2e_pkg::prod(qx, qy);
    p_nxt.wz = q2e_pkg::prod(qw, qz);
    p_nxt.xz = q2e_pkg::prod(qx, qz);
    p_nxt.wy = q2e_pkg::prod(qw, qy);
    p_nxt.yz = q2e_pkg::prod(qy, qz);
    p_nxt.wx = q2e_pkg::prod(qw, qx);
  end

  // matrix terms and clamped asin argument
  logic                              v1_r;
  logic                              rdy1;
  q2e_pkg::mat_t                     mat_r;
  q2e_pkg::mat_t                     mat_nxt;
  logic signed [q2e_pkg::A_W-1:0]    a_r;
  logic signed [q2e_pkg::A_W-1:0]    a_nxt;
  logic signed [q2e_pkg::MAT_W-1:0]  a_full;

  always_comb begin
    mat_nxt.m11 = ((q2e_pkg::MAT_W'(p_r.ww) + q2e_pkg::MAT_W'(p_r.xx)) <<< 1) - MAT_ONE;
    mat_nxt.m33 = ((q2e_pkg::MAT_W'(p_r.ww) + q2e_pkg::MAT_W'(p_r.zz)) <<< 1) - MAT_ONE;
    mat_nxt.m12 = (q2e_pkg::MAT_W'(p_r.xy) + q2e_pkg::MAT_W'(p_r.wz)) <<< 1;
    mat_nxt.m23 = (q2e_pkg::MAT_W'(p_r.yz) + q2e_pkg::MAT_W'(p_r.wx)) <<< 1;
    a_full = (q2e_pkg::MAT_W'(p_r.wy) - q2e_pkg::MAT_W'(p_r.xz)) <<< 1;
    mat_nxt.clamped = 1'b0;
    a_nxt = q2e_pkg::A_W'(a_full);
    if (a_full > MAT_ONE) begin
      a_nxt = q2e_pkg::A_W'(MAT_ONE);
      mat_nxt.clamped = 1'b1;
    end else if (a_full < -MAT_ONE) begin
      a_nxt = q2e_pkg::A_W'(-MAT_ONE);
      mat_nxt.clamped = 1'b1;
    end
  end

  // radicand one minus a squared
  logic                                v2_r;
  logic                                rdy2;
  q2e_pkg::sq_t                        sq0_r;
  q2e_pkg::sq_t                        sq0_nxt;
  logic signed [2*q2e_pkg::A_W-1:0]    asq;

  always_comb begin
    asq = a_r * a_r;
    sq0_nxt.rem  = (q2e_pkg::SQ_W'(1) << (2 * q2e_pkg::MAT_FRAC)) - asq[q2e_pkg::SQ_W-1:0];
    sq0_nxt.root = '0;
    sq0_nxt.a    = a_r;
    sq0_nxt.mat  = mat_r;
  end

  // square-root row
  logic         sq_v [0:NSQ];
  logic         sq_rd [0:NSQ];
  q2e_pkg::sq_t sq_d [0:NSQ];

  assign sq_v[0] = v2_r;
  assign sq_d[0] = sq0_r;

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    q2e_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .bit_idx  (q2e_pkg::IDX_W'(NSQ - 1 - k)),
      .up_valid (sq_v[k]),
      .up_ready (sq_rd[k]),
      .up_data  (sq_d[k]),
      .dn_valid (sq_v[k+1]),
      .dn_ready (sq_rd[k+1]),
      .dn_data  (sq_d[k+1])
    );
  end

  // quadrant fold
  logic         vp_r;
  logic         rdyp;
  q2e_pkg::cd_t pre_r;
  q2e_pkg::cd_t pre_nxt;

  always_comb begin
    pre_nxt.roll  = q2e_pkg::pre_rotate(q2e_pkg::CW'(sq_d[NSQ].mat.m23),
                                        q2e_pkg::CW'(sq_d[NSQ].mat.m33));
    pre_nxt.yaw   = q2e_pkg::pre_rotate(q2e_pkg::CW'(sq_d[NSQ].mat.m12),
                                        q2e_pkg::CW'(sq_d[NSQ].mat.m11));
    pre_nxt.pitch = q2e_pkg::pre_rotate(q2e_pkg::CW'(sq_d[NSQ].a),
                                        signed'(q2e_pkg::CW'(sq_d[NSQ].root)));
    pre_nxt.clamped = sq_d[NSQ].mat.clamped;
  end

  assign sq_rd[NSQ] = rdyp;

  // cordic row
  logic         cd_v [0:NCD];
  logic         cd_rd [0:NCD];
  q2e_pkg::cd_t cd_d [0:NCD];

  assign cd_v[0] = vp_r;
  assign cd_d[0] = pre_r;

  for (genvar k = 0; k < NCD; k++) begin : g_cordic
    q2e_cordic_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .iter     (q2e_pkg::IDX_W'(k)),
      .up_valid (cd_v[k]),
      .up_ready (cd_rd[k]),
      .up_data  (cd_d[k]),
      .dn_valid (cd_v[k+1]),
      .dn_ready (cd_rd[k+1]),
      .dn_data  (cd_d[k+1])
    );
  end

  // binary angle to 1/64 degree, scale
  logic                         vm_r;
  logic                         rdym;
  logic [q2e_pkg::CONV_W-1:0]   roll_p_r, pitch_p_r, yaw_p_r;
  logic                         clamp_m_r;
  logic [q2e_pkg::ANG_W-1:0]    u_roll, u_pitch, u_yaw;

  assign u_roll  = cd_d[NCD].roll.zero  ? '0 : cd_d[NCD].roll.z;
  assign u_pitch = cd_d[NCD].pitch.zero ? '0 : cd_d[NCD].pitch.z;
  assign u_yaw   = cd_d[NCD].yaw.zero   ? '0 : cd_d[NCD].yaw.z;
  assign cd_rd[NCD] = rdym;

  // round, wrap and limit
  logic                            vo_r;
  logic                            rdyo;
  logic [47:0]                     out_r;
  logic                            clamp_o_r;
  logic [47:0]                     out_nxt;
  logic [15:0]                     t_roll, t_pitch, t_yaw;
  logic signed [15:0]              s_roll, s_pitch;
  logic [q2e_pkg::CONV_W-1:0]      half;

  function automatic logic [15:0] wrap_units(input logic [q2e_pkg::CONV_W-1:0] p);
    logic [q2e_pkg::CONV_W-1:0] s;
    logic [15:0] t;
    s = p + (q2e_pkg::CONV_W'(1) << (q2e_pkg::ANG_W - 1));
    t = s[q2e_pkg::CONV_W-1:q2e_pkg::ANG_W];
    if (t >= 16'(q2e_pkg::UNITS)) t = '0;
    return t;
  endfunction

  always_comb begin
    half    = '0;
    t_roll  = wrap_units(roll_p_r);
    t_pitch = wrap_units(pitch_p_r);
    t_yaw   = wrap_units(yaw_p_r);
    s_roll  = signed'(t_roll);
    if (t_roll > 16'(q2e_pkg::HALF_UNITS)) s_roll = signed'(t_roll - 16'(q2e_pkg::UNITS));
    s_pitch = signed'(t_pitch);
    if (t_pitch > 16'(q2e_pkg::HALF_UNITS)) begin
      s_pitch = signed'(t_pitch - 16'(q2e_pkg::UNITS));
    end
    if (s_pitch > 16'sd5760) s_pitch = 16'(q2e_pkg::PITCH_LIMIT);
    if (s_pitch < -16'sd5760) s_pitch = -16'(q2e_pkg::PITCH_LIMIT);
    out_nxt = {4'b0, t_yaw[q2e_pkg::HEAD_W-1:0], s_pitch[q2e_pkg::PITCH_W-1:0],
               s_roll[q2e_pkg::ROLL_W-1:0]} | half;
  end

  // ready chain
  assign rdyo      = !vo_r || out_tready;
  assign rdym      = !vm_r || rdyo;
  assign rdyp      = !vp_r || cd_rd[0];
  assign rdy2      = !v2_r || sq_rd[0];
  assign rdy1      = !v1_r || rdy2;
  assign rdy0      = !v0_r || rdy1;
  assign in_tready = rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vp_r <= 1'b0;
      vm_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_tvalid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdyp) vp_r <= sq_v[NSQ];
      if (rdym) vm_r <= cd_v[NCD];
      if (rdyo) vo_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_tvalid) begin
      p_r <= p_nxt;
    end
    if (rdy1 && v0_r) begin
      mat_r <= mat_nxt;
      a_r   <= a_nxt;
    end
    if (rdy2 && v1_r) begin
      sq0_r <= sq0_nxt;
    end
    if (rdyp && sq_v[NSQ]) begin
      pre_r <= pre_nxt;
    end
    if (rdym && cd_v[NCD]) begin
      roll_p_r  <= q2e_pkg::CONV_W'(u_roll) * q2e_pkg::CONV_W'(q2e_pkg::UNITS);
      pitch_p_r <= q2e_pkg::CONV_W'(u_pitch) * q2e_pkg::CONV_W'(q2e_pkg::UNITS);
      yaw_p_r   <= q2e_pkg::CONV_W'(u_yaw) * q2e_pkg::CONV_W'(q2e_pkg::UNITS);
      clamp_m_r <= cd_d[NCD].clamped;
    end
    if (rdyo && vm_r) begin
      out_r     <= out_nxt;
      clamp_o_r <= clamp_m_r;
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = out_r;
  assign out_tuser  = clamp_o_r;

endmodule
`default_nettype wire

FILE: sv/q2e_checker.sv
// port-level checks of the quaternion to euler angle converter, bound to the top level
// depends on quaternion_to_euler_angles_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "quaternion_to_euler_angles_defines.svh"
module q2e_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [63:0] in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic        out_tuser
);

  logic signed [14:0] roll_s;
  logic signed [13:0] pitch_s;
  logic [14:0]        head_u;

  assign roll_s  = out_tdata[14:0];
  assign pitch_s = out_tdata[28:15];
  assign head_u  = out_tdata[43:29];

  // held result stays put
  `Q2E_ASSERT(a_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `Q2E_ASSERT(a_heading, out_tvalid |-> head_u < 15'd23040)
  `Q2E_ASSERT(a_pitch, out_tvalid |-> (pitch_s <= 14'sd5760) && (pitch_s >= -14'sd5760))
  `Q2E_ASSERT(a_roll, out_tvalid |-> (roll_s <= 15'sd11520) && (roll_s >= -15'sd11520) && out_tdata[47:44] == 4'b0)
  // no result straight out of reset
  `Q2E_ASSERT_ALWAYS(a_reset, rst_n && $past(!rst_n) |-> !out_tvalid)

  logic unused_ok;
  assign unused_ok = in_tvalid ^ in_tready ^ (^in_tdata);

endmodule

bind quaternion_to_euler_angles q2e_checker u_q2e_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
